[rtl/rcmp_pkg.sv]
`timescale 1ns / 1ps

package rcmp_pkg;

  localparam int unsigned MaxPacketBytesDef = 65535;

  localparam logic [15:0] MinLenReset = 16'd4;
  localparam logic [15:0] MinLenFloor = 16'd4;

  // first byte of a packet or sub-packet: version 2
  localparam logic [7:0] VerLo = 8'd128;
  localparam logic [7:0] VerHi = 8'd191;
  // second byte of a packet
  localparam logic [7:0] TypeLo = 8'd192;
  localparam logic [7:0] TypeHi = 8'd223;

  // sub-packet types
  localparam logic [7:0] PtLo = 8'd200;
  localparam logic [7:0] PtHi = 8'd207;
  localparam logic [7:0] PtSr = 8'd200;
  localparam logic [7:0] PtXr = 8'd207;

  localparam logic [7:0]  XrVoipKind  = 8'd7;
  localparam logic [18:0] SrMinLen    = 19'd24;
  localparam logic [18:0] VoipMinLen  = 19'd28;
  localparam logic [18:0] XrBodyStart = 19'd8;

  typedef struct packed {
    logic [7:0]  mos_cq;
    logic [7:0]  mos_lq;
    logic [7:0]  loss;
    logic [7:0]  discard;
    logic [31:0] pkt_count;
  } metrics_t;

  typedef struct packed {
    logic     is_rtcp;
    metrics_t metrics;
  } result_t;

endpackage

[rtl/rcmp_in_if.sv]
`timescale 1ns / 1ps

interface rcmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/rcmp_out_if.sv]
`timescale 1ns / 1ps

interface rcmp_out_if;
  logic        valid;
  logic        ready;
  logic        is_rtcp;
  logic [31:0] sender_packet_count;
  logic [7:0]  discard_rate;
  logic [7:0]  loss_rate;
  logic [7:0]  mos_listening;
  logic [7:0]  mos_conversational;

  modport source (
    output valid, output is_rtcp, output sender_packet_count, output discard_rate,
    output loss_rate, output mos_listening, output mos_conversational, input ready
  );
  modport sink (
    input valid, input is_rtcp, input sender_packet_count, input discard_rate,
    input loss_rate, input mos_listening, input mos_conversational, output ready
  );
endinterface

[rtl/rcmp_walker.sv]
`timescale 1ns / 1ps

module rcmp_walker import rcmp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [15:0] min_len_i,
  output result_t     res_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PACKET_BYTES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            head_ok_q, head_ok_d;
  logic            stopped_q, stopped_d;
  logic [18:0]     sub_off_q, sub_off_d;
  logic [18:0]     sub_total_q, sub_total_d;
  logic [7:0]      sub_type_q, sub_type_d;
  logic [18:0]     blk_off_q, blk_off_d;
  logic [18:0]     blk_total_q, blk_total_d;
  logic [7:0]      blk_kind_q, blk_kind_d;
  metrics_t        staged_q, staged_d;
  metrics_t        committed_q, committed_d;

  logic        ver_ok, type_ok, pt_ok, advance, voip_ok;
  logic [18:0] sub_nxt, blk_nxt, blk_start;
  logic [19:0] blk_end;
  logic [15:0] min_len, cnt_ext;

  assign ver_ok  = (byte_i >= VerLo) && (byte_i <= VerHi);
  assign type_ok = (byte_i >= TypeLo) && (byte_i <= TypeHi);
  assign pt_ok   = (byte_i >= PtLo) && (byte_i <= PtHi);
  assign min_len = (min_len_i < MinLenFloor) ? MinLenFloor : min_len_i;

  assign blk_start = sub_off_q - blk_off_q;
  assign blk_end   = {1'b0, blk_start} + {1'b0, blk_total_q};
  assign voip_ok   = (blk_off_q >= XrBodyStart) && (blk_kind_q == XrVoipKind) &&
                     (blk_total_q >= VoipMinLen) && (blk_end <= {1'b0, sub_total_q});

  always_comb begin
    cnt_d       = cnt_q;
    head_ok_d   = head_ok_q;
    stopped_d   = stopped_q;
    sub_off_d   = sub_off_q;
    sub_total_d = sub_total_q;
    sub_type_d  = sub_type_q;
    blk_off_d   = blk_off_q;
    blk_total_d = blk_total_q;
    blk_kind_d  = blk_kind_q;
    staged_d    = staged_q;
    committed_d = committed_q;
    advance     = 1'b0;
    sub_nxt     = sub_off_q + 19'd1;
    blk_nxt     = blk_off_q + 19'd1;
    cnt_ext     = '0;
    res_o       = '0;

    if (step_i) begin
      if (cnt_q >= CntMax) begin
        stopped_d = 1'b1;
      end else begin
        if (cnt_q == '0) begin
          head_ok_d = ver_ok;
        end else if (cnt_q == CntW'(1)) begin
          head_ok_d = head_ok_q && type_ok;
        end

        if (!stopped_q) begin
          priority if (sub_off_q == 19'd0) begin
            if (!ver_ok) begin
              stopped_d = 1'b1;
            end else begin
              staged_d  = committed_q;
              blk_off_d = '0;
              advance   = 1'b1;
            end
          end else if (sub_off_q == 19'd1) begin
            sub_type_d = byte_i;
            if (!pt_ok) begin
              stopped_d = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end else if (sub_off_q == 19'd2) begin
            sub_total_d = {1'b0, byte_i, 10'd0};
            advance     = 1'b1;
          end else if (sub_off_q == 19'd3) begin
            sub_total_d = sub_total_q + {9'd0, byte_i, 2'd0} + 19'd4;
            advance     = 1'b1;
          end else if (sub_type_q == PtSr) begin
            if (sub_total_q >= SrMinLen) begin
              unique case (sub_off_q)
                19'd20:  staged_d.pkt_count[31:24] = byte_i;
                19'd21:  staged_d.pkt_count[23:16] = byte_i;
                19'd22:  staged_d.pkt_count[15:8]  = byte_i;
                19'd23:  staged_d.pkt_count[7:0]   = byte_i;
                default: ;
              endcase
            end
            advance = 1'b1;
          end else if (sub_type_q == PtXr) begin
            if (sub_off_q >= XrBodyStart) begin
              unique case (blk_off_q)
                19'd0:   blk_kind_d  = byte_i;
                19'd2:   blk_total_d = {1'b0, byte_i, 10'd0};
                19'd3:   blk_total_d = blk_total_q + {9'd0, byte_i, 2'd0} + 19'd4;
                default: ;
              endcase
              if (voip_ok) begin
                unique case (blk_off_q)
                  19'd8:   staged_d.loss    = byte_i;
                  19'd9:   staged_d.discard = byte_i;
                  19'd26:  staged_d.mos_lq  = byte_i;
                  19'd27:  staged_d.mos_cq  = byte_i;
                  default: ;
                endcase
              end
              // wrap to the next block once this one is fully consumed
              if (blk_nxt >= 19'd4 && blk_nxt == blk_total_d) begin
                blk_off_d = '0;
              end else begin
                blk_off_d = blk_nxt;
              end
            end
            advance = 1'b1;
          end else begin
            advance = 1'b1;
          end

          if (advance) begin
            // commit staged values once the sub-packet is complete
            if (sub_nxt >= 19'd4 && sub_nxt == sub_total_d) begin
              committed_d = staged_d;
              sub_off_d   = '0;
              blk_off_d   = '0;
            end else begin
              sub_off_d = sub_nxt;
            end
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end

      if (last_i) begin
        cnt_ext       = 16'(cnt_d);
        res_o.is_rtcp = head_ok_d && (cnt_ext >= min_len);
        res_o.metrics = res_o.is_rtcp ? committed_d : '0;
        cnt_d         = '0;
        head_ok_d     = 1'b0;
        stopped_d     = 1'b0;
        sub_off_d     = '0;
        sub_total_d   = '0;
        sub_type_d    = '0;
        blk_off_d     = '0;
        blk_total_d   = '0;
        blk_kind_d    = '0;
        staged_d      = '0;
        committed_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      head_ok_q   <= 1'b0;
      stopped_q   <= 1'b0;
      sub_off_q   <= '0;
      sub_total_q <= '0;
      sub_type_q  <= '0;
      blk_off_q   <= '0;
      blk_total_q <= '0;
      blk_kind_q  <= '0;
      staged_q    <= '0;
      committed_q <= '0;
    end else begin
      cnt_q       <= cnt_d;
      head_ok_q   <= head_ok_d;
      stopped_q   <= stopped_d;
      sub_off_q   <= sub_off_d;
      sub_total_q <= sub_total_d;
      sub_type_q  <= sub_type_d;
      blk_off_q   <= blk_off_d;
      blk_total_q <= blk_total_d;
      blk_kind_q  <= blk_kind_d;
      staged_q    <= staged_d;
      committed_q <= committed_d;
    end
  end

endmodule

[rtl/rtcp_compound_metrics_parser_unit.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                             Note
// in_if     in   data_byte[7:0], last_byte                           one byte per transaction
// out_if    out  is_rtcp, sender_packet_count[31:0], discard_rate,   one record per packet,
//                loss_rate, mos_listening, mos_conversational        on its last byte
// cfg       in   cfg_we_i, cfg_wdata_i[15:0]                         min_packet_length
//
// One byte per cycle unless a stalled record holds the walker: a byte goes from
// the input register through the walker logic, which updates the packet state.
// A last byte's record is registered for out_if when the walker steps that byte.
// Reset clears all packet state and sets min_packet_length to 4.
// A stalled record holds the walker only when the next byte is also a last
// byte; other bytes keep flowing while the record waits.

module rtcp_compound_metrics_parser_unit import rcmp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcmp_in_if.sink     in_if,
  rcmp_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] min_len_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_vld_q;
  result_t     out_res_q;
  result_t     walk_res;
  logic        step;

  // advance the walker unless a last byte would overwrite a waiting record
  assign step        = in_vld_q && (!in_last_q || !out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || step;

  rcmp_walker #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .min_len_i (min_len_q),
    .res_o     (walk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_q <= in_if.data_byte;
      in_last_q <= in_if.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_res_q <= walk_res;
    end
  end

  assign out_if.valid               = out_vld_q;
  assign out_if.is_rtcp             = out_res_q.is_rtcp;
  assign out_if.sender_packet_count = out_res_q.metrics.pkt_count;
  assign out_if.discard_rate        = out_res_q.metrics.discard;
  assign out_if.loss_rate           = out_res_q.metrics.loss;
  assign out_if.mos_listening       = out_res_q.metrics.mos_lq;
  assign out_if.mos_conversational  = out_res_q.metrics.mos_cq;

endmodule
